// ----- src/cdfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Checked decimal fixed-point ALU package
// Item types, operation and status codes, and the internal stage records.
// ----------------------------------------------------------------------------
package cdfa_pkg;

    localparam int DEC_DIGITS = 9;
    localparam int QUOT_BITS  = 128;

    function automatic logic [63:0] pow10(input int digits);
        logic [63:0] s;
        s = 64'd1;
        for (int i = 0; i < 18; i++) begin
            if (i < digits) begin
                s = s * 64'd10;
            end
        end
        return s;
    endfunction

    localparam logic [63:0] SCALE    = pow10(DEC_DIGITS);
    localparam logic [63:0] MIN_I64  = 64'h8000_0000_0000_0000;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_CVT = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] result;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic        direct;
        logic [1:0]  status;
        logic [63:0] result;
        logic        neg;
        logic [1:0]  fail_code;
    } t_ctl;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
        logic [63:0] divisor;
        t_ctl        ctl;
    } t_prod;

    typedef struct packed {
        logic [127:0] work;
        logic [63:0]  rem;
        logic [63:0]  divisor;
        t_ctl         ctl;
    } t_div;

endpackage
`default_nettype wire

// ----- src/cdfa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Front stage
// Decodes the operation, finishes add, subtract and negate, and forms the
// four 32x32 partial products of |lhs| times |rhs|, or |lhs| times SCALE.
// ----------------------------------------------------------------------------
module cdfa_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cdfa_pkg::t_in_item i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cdfa_pkg::t_prod         o_prod
);
    import cdfa_pkg::*;

    logic        r_valid;
    t_prod       r_prod;
    t_prod       n_prod;
    logic [63:0] a, b, ma, mb, ms, ns, sum;
    logic [63:0] x, y;

    always_comb begin
        a   = i_item.lhs;
        b   = i_item.rhs;
        ma  = a[63] ? (64'd0 - a) : a;
        mb  = b[63] ? (64'd0 - b) : b;
        ns  = 64'd0 - b;
        ms  = (i_item.operation == OP_SUB) ? ns : b;
        sum = a + ms;
        x   = ma;
        y   = SCALE;
        n_prod.divisor       = 64'd1;
        n_prod.ctl.direct    = 1'b1;
        n_prod.ctl.status    = ST_OK;
        n_prod.ctl.result    = 64'd0;
        n_prod.ctl.neg       = a[63] ^ b[63];
        n_prod.ctl.fail_code = ST_OVERFLOW;
        unique case (i_item.operation)
            OP_ADD, OP_SUB: begin
                if ((i_item.operation == OP_SUB && b == MIN_I64) ||
                    (a[63] == ms[63] && sum[63] != a[63])) begin
                    n_prod.ctl.status = ST_OVERFLOW;
                end else begin
                    n_prod.ctl.result = sum;
                end
            end
            OP_NEG: begin
                if (a == MIN_I64) begin
                    n_prod.ctl.status = ST_OVERFLOW;
                end else begin
                    n_prod.ctl.result = 64'd0 - a;
                end
            end
            OP_MUL: begin
                n_prod.ctl.direct = 1'b0;
                y                 = mb;
                n_prod.divisor    = SCALE;
            end
            OP_DIV: begin
                if (b == 64'd0) begin
                    n_prod.ctl.status = ST_DIVZERO;
                end else begin
                    n_prod.ctl.direct = 1'b0;
                    n_prod.divisor    = mb;
                end
            end
            OP_CVT: begin
                n_prod.ctl.direct    = 1'b0;
                n_prod.ctl.neg       = a[63];
                n_prod.ctl.fail_code = ST_RANGE;
            end
            default: begin
                n_prod.ctl.status = ST_OVERFLOW;
            end
        endcase
        n_prod.ll = {32'd0, x[31:0]}  * {32'd0, y[31:0]};
        n_prod.lh = {32'd0, x[31:0]}  * {32'd0, y[63:32]};
        n_prod.hl = {32'd0, x[63:32]} * {32'd0, y[31:0]};
        n_prod.hh = {32'd0, x[63:32]} * {32'd0, y[63:32]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
endmodule
`default_nettype wire

// ----- src/cdfa_acc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Product accumulate stage
// Sums the partial products into the 128-bit dividend for the divider chain.
// ----------------------------------------------------------------------------
module cdfa_acc (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cdfa_pkg::t_prod i_prod,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output cdfa_pkg::t_div       o_div
);
    import cdfa_pkg::*;

    logic  r_valid;
    t_div  r_div;
    t_div  n_div;

    always_comb begin
        n_div.work    = {64'd0, i_prod.ll} + {32'd0, i_prod.lh, 32'd0}
                      + {32'd0, i_prod.hl, 32'd0} + {i_prod.hh, 64'd0};
        n_div.rem     = 64'd0;
        n_div.divisor = i_prod.divisor;
        n_div.ctl     = i_prod.ctl;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// ----- src/cdfa_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in the next dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module cdfa_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire cdfa_pkg::t_div i_div,
    output logic                o_valid,
    input  wire logic           i_ready,
    output cdfa_pkg::t_div      o_div
);
    import cdfa_pkg::*;

    logic        r_valid;
    t_div        r_div;
    t_div        n_div;
    logic [64:0] t, diff;
    logic        ge;

    always_comb begin
        t     = {i_div.rem, i_div.work[127]};
        diff  = t - {1'b0, i_div.divisor};
        ge    = (t >= {1'b0, i_div.divisor});
        n_div = i_div;
        n_div.rem  = ge ? diff[63:0] : t[63:0];
        n_div.work = {i_div.work[126:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule
`default_nettype wire

// ----- src/checked_decimal_fixed_alu_top.sv -----
`default_nettype none
// Path of an accepted item to its result: front stage, product sum, 128
// divider cells, output register. Throughput: one item per cycle when no
// stage is stalled; every divider cell holds its own item.
// Each stage holds its item under a downstream stall, so bubbles are absorbed.
// Reset clears all valid flags synchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// Checked decimal fixed-point ALU
// Add, subtract, negate, multiply, divide and conversion on 64-bit raw values
// with nine fractional digits, with overflow, divide-by-zero and range status.
// ----------------------------------------------------------------------------
module checked_decimal_fixed_alu_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire cdfa_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output cdfa_pkg::t_out_item      o_out_data
);
    import cdfa_pkg::*;

    logic      front_ready, front_valid, acc_ready;
    t_prod     front_prod;
    logic      c_valid [0:QUOT_BITS];
    logic      c_ready [0:QUOT_BITS];
    t_div      c_div   [0:QUOT_BITS];
    logic      r_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_ready;
    logic      fits;
    logic [127:0] q;

    cdfa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(front_ready), .i_item(i_in_data),
        .o_valid(front_valid), .i_ready(acc_ready), .o_prod(front_prod)
    );

    cdfa_acc u_acc (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(front_valid), .o_ready(acc_ready), .i_prod(front_prod),
        .o_valid(c_valid[0]), .i_ready(c_ready[0]), .o_div(c_div[0])
    );

    for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
        cdfa_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]), .o_ready(c_ready[g]), .i_div(c_div[g]),
            .o_valid(c_valid[g+1]), .i_ready(c_ready[g+1]), .o_div(c_div[g+1])
        );
    end

    assign out_ready               = !r_valid || !i_out_stall;
    assign c_ready[QUOT_BITS]      = out_ready;
    assign o_in_stall              = !front_ready;

    always_comb begin
        q    = c_div[QUOT_BITS].work;
        fits = (q[127:64] == 64'd0) &&
               (c_div[QUOT_BITS].ctl.neg ? (q[63:0] <= MIN_I64) : !q[63]);
        if (c_div[QUOT_BITS].ctl.direct) begin
            n_out.status = c_div[QUOT_BITS].ctl.status;
            n_out.result = c_div[QUOT_BITS].ctl.result;
        end else if (fits) begin
            n_out.status = ST_OK;
            n_out.result = c_div[QUOT_BITS].ctl.neg ? (64'd0 - q[63:0]) : q[63:0];
        end else begin
            n_out.status = c_div[QUOT_BITS].ctl.fail_code;
            n_out.result = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= c_valid[QUOT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && c_valid[QUOT_BITS]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.result == 64'd0)
        else $error("error status with nonzero result");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !u_front.o_valid || acc_ready)
        else $error("input taken while front stage is blocked");

endmodule
`default_nettype wire
